>>> src/eeg_serial_frame_parser_unit_defines.svh
// Assertion macros shared by the frame parser RTL.
`ifndef EEG_SERIAL_FRAME_PARSER_UNIT_DEFINES_SVH
`define EEG_SERIAL_FRAME_PARSER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define EEG_SFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define EEG_SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/eeg_sfp_pkg.sv
// Types and fixed constants of the serial frame parser.
package eeg_sfp_pkg;

  localparam int PHASE_W = 6;

  // Frame phase codes before the data bytes
  localparam logic [PHASE_W-1:0] PH_HUNT    = 6'd0;
  localparam logic [PHASE_W-1:0] PH_HDR2    = 6'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP    = 6'd2;
  localparam logic [PHASE_W-1:0] DATA_START = 6'd3;

  // Header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hC0;
  localparam logic [7:0] HDR_SECOND = 8'hA0;

  // Gain register
  localparam logic [1:0]  GAIN_ADDR  = 2'd0;
  localparam logic [31:0] GAIN_RESET = 32'h0100_0000;

  // One decoded sample handed from the parser to the scaling stage
  typedef struct packed {
    logic [2:0]         channel;
    logic signed [23:0] raw;
    logic               last;
  } eeg_sfp_sample_t;

endpackage

>>> src/eeg_sfp_parser.sv
// Byte-level frame phase tracker and sample assembler.
module eeg_sfp_parser
  import eeg_sfp_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            emit,
  output eeg_sfp_sample_t sample
);

  localparam int CW = $clog2(CHANNELS + 1);
  localparam logic [PHASE_W-1:0] DATA_END = PHASE_W'(3 + 1 + 3 * CHANNELS);
  localparam logic [PHASE_W-1:0] TAIL_END = PHASE_W'(3 + 1 + 3 * CHANNELS + 6);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [CW-1:0]      ch_cnt_r, ch_cnt_nxt;
  logic [23:0]        bytes_r, bytes_nxt;
  logic               emit_now;

  // Advance the frame phase on each byte
  always_comb begin
    phase_nxt  = phase_r;
    sub_nxt    = sub_r;
    ch_cnt_nxt = ch_cnt_r;
    bytes_nxt  = bytes_r;
    emit_now   = 1'b0;
    if (phase_r == PH_HUNT) begin
      phase_nxt = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
    end else if (phase_r == PH_HDR2) begin
      phase_nxt = (rx_byte == HDR_SECOND) ? PH_SKIP : PH_HUNT;
    end else if (phase_r == PH_SKIP) begin
      phase_nxt  = DATA_START;
      sub_nxt    = 2'd0;
      ch_cnt_nxt = '0;
    end else if (phase_r < DATA_END) begin
      // A sample completes on the byte after its third byte
      emit_now = (sub_r == 2'd0) && (phase_r != DATA_START);
      if (emit_now) begin
        ch_cnt_nxt = ch_cnt_r + CW'(1);
      end
      sub_nxt   = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
      bytes_nxt = {bytes_r[15:0], rx_byte};
      phase_nxt = phase_r + PHASE_W'(1);
    end else if (phase_r < TAIL_END) begin
      // Trailer must be all zero, else resync
      phase_nxt = (rx_byte == 8'd0) ? phase_r + PHASE_W'(1) : PH_HUNT;
    end else begin
      // Drop the final byte
      phase_nxt = PH_HUNT;
    end
  end

  // Hold state unless a byte is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      sub_r    <= 2'd0;
      ch_cnt_r <= '0;
      bytes_r  <= 24'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      sub_r    <= sub_nxt;
      ch_cnt_r <= ch_cnt_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  assign emit           = accept && emit_now;
  assign sample.channel = 3'(ch_cnt_r);
  assign sample.raw     = $signed(bytes_r);
  assign sample.last    = (ch_cnt_r == CW'(CHANNELS - 1));

endmodule

>>> src/eeg_serial_frame_parser_unit.sv
// Serial EEG frame parser: one received byte per transaction in, scaled samples out.
//
// Input channel: in_valid / in_stall with in_rx_byte, one link byte per
// transaction. Output channel: out_valid / out_stall with out_channel,
// out_raw_sample, out_scaled_sample (raw times gain, 24 fraction bits) and
// out_last_channel. A frame is C0 A0, one ignored byte, three bytes per
// channel, a spare byte, six zero bytes and a final byte; each sample leaves
// once the byte after its third byte is accepted.
// Throughput: one byte per cycle while in_stall is low. The sample is registered
// in the first stage when its byte is accepted, and the product is registered in
// the output stage when that stage is free, which raises out_valid. The gain multiply
// (24 x 33 bits) is combinational between the first stage and the output stage.
// The gain register sits at APB byte address 0, readable and writable;
// write it only while no frame bytes are in flight.
// Reset (rst_n low, synchronous) returns the parser to header hunt, empties
// both stages and restores gain to 1.0. When the receiver stalls, the
// result holds, one more sample waits in the first stage, and in_stall
// rises only once that stage is also occupied.
`include "eeg_serial_frame_parser_unit_defines.svh"
module eeg_serial_frame_parser_unit
  import eeg_sfp_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_channel,
  output logic signed [23:0] out_raw_sample,
  output logic signed [55:0] out_scaled_sample,
  output logic               out_last_channel,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [2:0] LAST_CH = 3'(CHANNELS - 1);

  logic            in_acc;
  logic            b_load;
  logic            emit;
  eeg_sfp_sample_t sample;
  logic [31:0]     gain_r;
  logic            a_valid_r;
  eeg_sfp_sample_t a_sample_r;
  logic            out_valid_r;
  logic signed [55:0] prod;

  // Register access
  assign pready = 1'b1;
  assign prdata = (paddr == GAIN_ADDR) ? gain_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == GAIN_ADDR)) begin
      gain_r <= pwdata;
    end
  end

  // Handshake: output stage frees when empty or taken
  assign b_load   = !out_valid_r || !out_stall;
  assign in_stall = a_valid_r && !b_load;
  assign in_acc   = in_valid && !in_stall;

  eeg_sfp_parser #(
    .CHANNELS(CHANNELS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .rx_byte(in_rx_byte),
    .emit   (emit),
    .sample (sample)
  );

  // First stage: hold the decoded sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= emit;
    end else if (b_load) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      a_sample_r <= sample;
    end
  end

  // Signed sample times unsigned gain
  assign prod = $signed({{32{a_sample_r.raw[23]}}, a_sample_r.raw})
              * $signed({24'd0, gain_r});

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_load) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid_r) begin
      out_channel       <= a_sample_r.channel;
      out_raw_sample    <= a_sample_r.raw;
      out_scaled_sample <= prod;
      out_last_channel  <= a_sample_r.last;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  `EEG_SFP_ASSERT_NOW(a_last_ch, out_valid && out_last_channel, out_channel == LAST_CH, "bad last")
  `EEG_SFP_ASSERT_NOW(a_full_stall, a_valid_r && out_valid_r && out_stall, in_stall, "no stall")
  `EEG_SFP_ASSERT_NEXT(a_move, a_valid_r && b_load, out_valid, "sample lost")
  `EEG_SFP_ASSERT_NEXT(a_raw, a_valid_r && b_load, out_raw_sample == $past(a_sample_r.raw), "raw")

endmodule

>>> tb/sv/eeg_serial_frame_parser_unit_test.sv
// Self-checking testbench for the serial EEG frame parser unit.
`timescale 1ns / 100ps

module eeg_serial_frame_parser_unit_test
  import eeg_sfp_pkg::*;
();

  localparam int CHANNELS       = 8;
  localparam int DATA_END       = DATA_START + 1 + 3 * CHANNELS;
  localparam int TRAILER_ZEROS  = 6;
  localparam int TRAILER_END    = DATA_END + TRAILER_ZEROS;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 65;
  localparam int RANDOM_PHASES  = 5;
  localparam int CYCLE_LIMIT    = 200000;

  // One expected output sample
  typedef struct {
    logic [2:0]         channel;
    logic signed [23:0] raw;
    logic signed [55:0] scaled;
    logic               last_ch;
  } sample_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_channel;
  logic signed [23:0] out_raw_sample;
  logic signed [55:0] out_scaled_sample;
  logic               out_last_channel;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Parser state mirrored by the testbench
  logic [PHASE_W-1:0] phase_q;
  logic [23:0]        window_q;
  logic [31:0]        gain_q;

  sample_t     samples_due[$];
  logic [23:0] frame_samples[CHANNELS];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b1;

  eeg_serial_frame_parser_unit #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_raw_sample   (out_raw_sample),
    .out_scaled_sample(out_scaled_sample),
    .out_last_channel (out_last_channel),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Generate the 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still due", cycle_count,
               samples_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Pick an idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Multiply a signed sample by the unsigned gain, keep 56 bits
  function automatic logic signed [55:0] scale_sample(input logic signed [23:0] raw,
                                                      input logic [31:0] gain);
    longint signed r;
    longint signed g;
    longint signed p;
    r = longint'(raw);
    g = {32'd0, gain};
    p = r * g;
    return p[55:0];
  endfunction

  // Advance the mirrored parser by one accepted byte
  task automatic track_frame_byte(input logic [7:0] b);
    sample_t     s;
    int unsigned off;
    int unsigned ch;
    if (phase_q == PH_HUNT) begin
      phase_q = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
    end else if (phase_q == PH_HDR2) begin
      phase_q = (b == HDR_SECOND) ? PH_SKIP : PH_HUNT;
    end else if (phase_q == PH_SKIP) begin
      phase_q = DATA_START;
    end else if (phase_q < DATA_END) begin
      off = phase_q - DATA_START;
      // Emit the sample completed by the previous three bytes
      if (off > 0 && (off % 3) == 0) begin
        ch        = off / 3 - 1;
        s.channel = ch[2:0];
        s.raw     = window_q;
        s.scaled  = scale_sample(window_q, gain_q);
        s.last_ch = (ch == CHANNELS - 1);
        samples_due.push_back(s);
      end
      window_q = {window_q[15:0], b};
      phase_q  = phase_q + 1'b1;
    end else if (phase_q < TRAILER_END) begin
      phase_q = (b == 8'h00) ? phase_q + 1'b1 : PH_HUNT;
    end else begin
      phase_q = PH_HUNT;
    end
  endtask

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // Offer one byte after a random gap, hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    track_frame_byte(b);
    bytes_sent++;
  endtask

  // Send one frame; break_at below TRAILER_ZEROS puts a nonzero byte there
  task automatic send_frame(input logic [7:0] skip_b, input logic [7:0] spare_b,
                            input logic [7:0] tail_b, input int break_at);
    int k;
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(skip_b);
    for (k = 0; k < CHANNELS; k++) begin
      send_byte(frame_samples[k][23:16]);
      send_byte(frame_samples[k][15:8]);
      send_byte(frame_samples[k][7:0]);
    end
    send_byte(spare_b);
    k = 0;
    while (k < TRAILER_ZEROS && k != break_at) begin
      send_byte(8'h00);
      k++;
    end
    if (k < TRAILER_ZEROS) send_byte(8'($urandom_range(1, 255)));
    else send_byte(tail_b);
  endtask

  // Fill the frame with random samples, biased toward the extremes
  task automatic fill_random_samples();
    int k;
    for (k = 0; k < CHANNELS; k++) begin
      case ($urandom_range(0, 7))
        0:       frame_samples[k] = 24'h7F_FFFF;
        1:       frame_samples[k] = 24'h80_0000;
        2:       frame_samples[k] = 24'h00_0000;
        3:       frame_samples[k] = 24'hFF_FFFF;
        default: frame_samples[k] = 24'($urandom);
      endcase
    end
  endtask

  // Drop valid and wait until every sample is out and the pipe is empty
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the gain register through the setup and access phases
  task automatic write_gain(input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAIN_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gain_q = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver side: long hold-off on request, else random stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each sample transaction against the oldest expectation
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (samples_due.size() == 0) begin
        report_mismatch("unexpected sample, channel", out_channel, 64'd0);
      end else begin
        want = samples_due.pop_front();
        if (out_channel !== want.channel)
          report_mismatch("channel", out_channel, want.channel);
        if (out_raw_sample !== want.raw)
          report_mismatch("raw_sample", out_raw_sample, want.raw);
        if (out_scaled_sample !== want.scaled)
          report_mismatch("scaled_sample", out_scaled_sample, want.scaled);
        if (out_last_channel !== want.last_ch)
          report_mismatch("last_channel", out_last_channel, want.last_ch);
      end
    end
  end

  // Broken headers: C0 then non-A0, a second C0 not rechecked, stray A0
  task automatic test_header_breaks();
    send_byte(HDR_FIRST);
    send_byte(8'h55);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(HDR_SECOND);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // Full frame with extreme sample values at the reset gain
  task automatic test_extreme_frame();
    frame_samples[0] = 24'h7F_FFFF;
    frame_samples[1] = 24'h80_0000;
    frame_samples[2] = 24'h00_0000;
    frame_samples[3] = 24'hFF_FFFF;
    frame_samples[4] = 24'h00_0001;
    frame_samples[5] = 24'h80_0001;
    frame_samples[6] = 24'h12_3456;
    frame_samples[7] = 24'hED_CBA9;
    send_frame(8'hFF, 8'h00, 8'hFF, TRAILER_ZEROS);
    // Nonzero trailer byte sends the parser back to hunting
    fill_random_samples();
    send_frame(8'h00, 8'hFF, 8'h00, 2);
  endtask

  // Hold the receiver off while the sender keeps offering frames
  task automatic test_backpressure();
    settle_idle();
    write_gain(32'hFFFF_FFFF);
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    fill_random_samples();
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), TRAILER_ZEROS);
    fill_random_samples();
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), TRAILER_ZEROS);
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, plus breaks and noise
  task automatic test_random_traffic();
    int p;
    int stop_at;
    int kind;
    int n;
    int k;
    int r;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle_idle();
      case (p)
        0:       write_gain(32'h0000_0000);
        1:       write_gain(32'hFFFF_FFFF);
        2:       write_gain(32'h0000_0001);
        3:       write_gain($urandom);
        default: write_gain(GAIN_RESET);
      endcase
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        gaps_on = ($urandom_range(0, 4) != 0);
        kind    = $urandom_range(0, 9);
        if (kind < 8) begin
          fill_random_samples();
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)),
                     (kind == 7) ? $urandom_range(0, TRAILER_ZEROS - 1) : TRAILER_ZEROS);
        end else begin
          // Noise with header bytes mixed in
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            if (r < 3) send_byte(HDR_FIRST);
            else if (r < 5) send_byte(HDR_SECOND);
            else if (r < 6) send_byte(8'h00);
            else send_byte(8'($urandom_range(0, 255)));
          end
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Reset, run the tests in turn, drain and decide
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    phase_q    = PH_HUNT;
    window_q   = '0;
    gain_q     = GAIN_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_header_breaks();
    test_extreme_frame();
    test_backpressure();
    test_random_traffic();

    settle_idle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
